>>> rtl/ttlc_pkg.sv
// ttlc_pkg: shared constants and sequencer state type for two_term_lattice_count
// no dependencies; used by rtl/ttlc_div.sv and rtl/two_term_lattice_count.sv

package ttlc_pkg;

    localparam int AMOUNT_WIDTH_DEF = 20;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> rtl/ttlc_div.sv
// ttlc_div: restoring divider, one quotient bit per cycle, registered quotient
// depends on ttlc_pkg for the default operand width

module ttlc_div #(
    parameter int AMOUNT_WIDTH = ttlc_pkg::AMOUNT_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [AMOUNT_WIDTH-1:0] i_dividend,
    input  logic [AMOUNT_WIDTH-1:0] i_divisor,
    output logic                    o_done,
    output logic [AMOUNT_WIDTH-1:0] o_quotient
);

    localparam int CNT_W = $clog2(AMOUNT_WIDTH + 1);

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [AMOUNT_WIDTH-1:0] r_rem, n_rem;
    logic [AMOUNT_WIDTH-1:0] r_quo, n_quo;
    logic [AMOUNT_WIDTH-1:0] r_div, n_div;

    logic [AMOUNT_WIDTH:0]   w_shift;
    logic [AMOUNT_WIDTH+1:0] w_diff;
    logic                    w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[AMOUNT_WIDTH-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_div};
        w_ge    = !w_diff[AMOUNT_WIDTH+1];

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(AMOUNT_WIDTH);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[AMOUNT_WIDTH-1:0] : w_shift[AMOUNT_WIDTH-1:0];
            n_quo = {r_quo[AMOUNT_WIDTH-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/two_term_lattice_count.sv
// two_term_lattice_count: counts pairs (x, y) >= 0 with x*cost_a + y*cost_b <= budget
// depends on ttlc_pkg and ttlc_div
//
// usage:
//   one request beat in on s_axis (budget, cost_a, cost_b), one result beat out
//   on m_axis (way_count). s_axis_tready is high only while no request is in work.
//   the larger cost is the stride; for each multiple of it up to the budget the
//   shared serial divider forms (budget - spent) / smaller cost, and the sum of
//   one plus each quotient is accumulated.
//   there are floor(budget / max cost) + 1 terms, each waiting on the divider that
//   retires one quotient bit per cycle. a zero cost returns 0 without a division.
//   the result sits in an output register; while m_axis_tready is low the
//   finished count waits there, and the next request is taken only once the
//   previous result has moved into that register.
//   reset (synchronous, active low) drops any request in work and any
//   undelivered result, and the block comes back ready.

module two_term_lattice_count #(
    parameter int AMOUNT_WIDTH = ttlc_pkg::AMOUNT_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // budget, cost_a, cost_b from bit 0 up, zero padded
    input  logic [((3*AMOUNT_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // way_count from bit 0 up, zero padded
    output logic [((2*AMOUNT_WIDTH+7)/8)*8-1:0]        m_axis_tdata
);

    localparam int W      = AMOUNT_WIDTH;
    localparam int CW     = 2 * AMOUNT_WIDTH;
    localparam int OUT_TW = ((2 * AMOUNT_WIDTH + 7) / 8) * 8;

    ttlc_pkg::t_state r_state, n_state;

    logic [W-1:0]  r_budget, n_budget;
    logic [W-1:0]  r_stride, n_stride;
    logic [W-1:0]  r_small, n_small;
    logic [W:0]    r_spent, n_spent;
    logic [CW-1:0] r_total, n_total;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_data, n_out_data;

    logic [W-1:0]  w_budget, w_cost_a, w_cost_b;
    logic          w_in_acc;
    logic          w_div_start;
    logic          w_div_done;
    logic [W-1:0]  w_dividend;
    logic [W-1:0]  w_quotient;

    assign w_budget = s_axis_tdata[W-1:0];
    assign w_cost_a = s_axis_tdata[2*W-1:W];
    assign w_cost_b = s_axis_tdata[3*W-1:2*W];

    assign s_axis_tready = (r_state == ttlc_pkg::S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_dividend    = r_budget - r_spent[W-1:0];

    ttlc_div #(
        .AMOUNT_WIDTH(AMOUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_small),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_budget    = r_budget;
        n_stride    = r_stride;
        n_small     = r_small;
        n_spent     = r_spent;
        n_total     = r_total;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_div_start = 1'b0;

        case (r_state)
            ttlc_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_budget = w_budget;
                    n_stride = (w_cost_a >= w_cost_b) ? w_cost_a : w_cost_b;
                    n_small  = (w_cost_a >= w_cost_b) ? w_cost_b : w_cost_a;
                    n_spent  = '0;
                    n_total  = '0;
                    if (w_cost_a == '0 || w_cost_b == '0) begin
                        n_state = ttlc_pkg::S_DONE;
                    end else begin
                        n_state = ttlc_pkg::S_START;
                    end
                end
            end
            ttlc_pkg::S_START: begin
                if (r_spent > {1'b0, r_budget}) begin
                    n_state = ttlc_pkg::S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ttlc_pkg::S_DIV;
                end
            end
            ttlc_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_total = r_total + CW'(w_quotient) + CW'(1);
                    n_spent = r_spent + {1'b0, r_stride};
                    n_state = ttlc_pkg::S_START;
                end
            end
            ttlc_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_total;
                    n_state     = ttlc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttlc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttlc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_budget   <= n_budget;
        r_stride   <= n_stride;
        r_small    <= n_small;
        r_spent    <= n_spent;
        r_total    <= n_total;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'(r_out_data);

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != ttlc_pkg::S_IDLE)
        else $error("request beat accepted but sequencer stayed idle");

    a_done_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ttlc_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_start_only_in_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_state == ttlc_pkg::S_START && r_spent <= {1'b0, r_budget}))
        else $error("divider started with spent beyond budget");

    a_small_not_above_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttlc_pkg::S_START || r_state == ttlc_pkg::S_DIV) |-> r_small <= r_stride)
        else $error("smaller cost exceeds stride");

    a_result_loaded_on_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttlc_pkg::S_DONE && n_state == ttlc_pkg::S_IDLE) |=> m_axis_tvalid)
        else $error("finished count not presented on the result channel");

endmodule
